@@ rtl/ipid_pkg.sv @@
package ipid_pkg;

  // default number of fraction bits of gains, increment and drive
  localparam int unsigned FRAC_BITS_DEF = 8;

  // field and datapath widths
  localparam int unsigned IN_W    = 16;
  localparam int unsigned ERR_W   = 17;
  localparam int unsigned DP_W    = 18;
  localparam int unsigned DD_W    = 19;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned PP_W    = GAIN_W + 1 + DP_W;
  localparam int unsigned PI_W    = GAIN_W + 1 + ERR_W;
  localparam int unsigned PD_W    = GAIN_W + 1 + DD_W;
  localparam int unsigned INC_W   = PD_W + 2;
  localparam int unsigned DRIVE_W = 24;
  localparam int unsigned DUTY_W  = 16;
  localparam int unsigned ACC_W   = INC_W + 1;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // register reset values
  localparam logic [15:0]        STEP_LIMIT_RST  = 16'd1536;
  localparam logic signed [15:0] DRIVE_UPPER_RST = 16'sd100;
  localparam logic signed [15:0] DRIVE_LOWER_RST = -16'sd100;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_PROP   = 3'd0,
    REG_GAIN_INTEG  = 3'd1,
    REG_GAIN_DERIV  = 3'd2,
    REG_STEP_LIMIT  = 3'd3,
    REG_DRIVE_UPPER = 3'd4,
    REG_DRIVE_LOWER = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_prop;
    logic [GAIN_W-1:0]  gain_integ;
    logic [GAIN_W-1:0]  gain_deriv;
    logic [15:0]        step_limit;
    logic signed [15:0] drive_upper;
    logic signed [15:0] drive_lower;
  } cfg_t;

  typedef struct packed {
    logic signed [IN_W-1:0] setpoint;
    logic signed [IN_W-1:0] measured;
  } in_t;

  typedef struct packed {
    logic signed [DUTY_W-1:0]  duty;
    logic signed [DRIVE_W-1:0] drive_fixed;
  } out_t;

  // error terms handed from the error stage to the multiply stage
  typedef struct packed {
    logic signed [ERR_W-1:0] e0;
    logic signed [DP_W-1:0]  dp;
    logic signed [DD_W-1:0]  dd;
  } diff_t;

  // pipeline handshake between two stages
  typedef struct packed {
    logic vld;
    logic take;
  } hs_t;

endpackage

@@ rtl/incremental_pid_with_slew_clamp.sv @@
// Incremental (velocity-form) PID with a per-tick slew clamp and drive saturation.
// Each input beat carries a setpoint and a measurement; each one yields exactly one
// output beat with the whole-unit duty and the Q.FRAC_BITS drive. The block takes a
// new beat every cycle while the output is not stalled, and each result passes through
// the error register, multiply stage, sum and slew clamp stage and accumulate and output
// stage in that order; the drive feedback add and bound compare in the last stage
// set the clock path. While the output is stalled the four stages take up to four
// beats before the input stalls. Registers are written through the configuration
// port at any index 0..5 and should only change while no beat is in flight. Out of
// reset the errors and the drive are zero; no clearing pass is needed.
module incremental_pid_with_slew_clamp #(
  parameter int unsigned FRAC_BITS = ipid_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  ipid_pkg::in_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output ipid_pkg::out_t                   out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ipid_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ipid_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  ipid_pkg::cfg_t                     cfg;
  ipid_pkg::hs_t                      err_hs, mac_hs;
  ipid_pkg::diff_t                    diff;
  logic                               mac_take, drv_take;
  logic signed [ipid_pkg::INC_W-1:0]  inc;

  // configuration registers
  ipid_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // error history and differences
  ipid_err u_err (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .dn_o       (err_hs),
    .dn_take_i  (mac_take),
    .diff_o     (diff)
  );

  // gain products, sum and slew clamp
  ipid_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .up_vld_i  (err_hs.vld),
    .up_take_o (mac_take),
    .diff_i    (diff),
    .dn_o      (mac_hs),
    .dn_take_i (drv_take),
    .inc_o     (inc)
  );

  // drive accumulator and output register
  ipid_drive #(
    .FRAC_BITS (FRAC_BITS)
  ) u_drive (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .up_vld_i    (mac_hs.vld),
    .up_take_o   (drv_take),
    .inc_i       (inc),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/ipid_cfg.sv @@
module ipid_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ipid_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ipid_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output ipid_pkg::cfg_t                      cfg_o
);

  ipid_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  // register decode, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (ipid_pkg::cfg_idx_e'(cfg_index_i))
        ipid_pkg::REG_GAIN_PROP:   cfg_d.gain_prop   = cfg_data_i;
        ipid_pkg::REG_GAIN_INTEG:  cfg_d.gain_integ  = cfg_data_i;
        ipid_pkg::REG_GAIN_DERIV:  cfg_d.gain_deriv  = cfg_data_i;
        ipid_pkg::REG_STEP_LIMIT:  cfg_d.step_limit  = cfg_data_i;
        ipid_pkg::REG_DRIVE_UPPER: cfg_d.drive_upper = $signed(cfg_data_i);
        ipid_pkg::REG_DRIVE_LOWER: cfg_d.drive_lower = $signed(cfg_data_i);
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_prop   <= '0;
      cfg_q.gain_integ  <= '0;
      cfg_q.gain_deriv  <= '0;
      cfg_q.step_limit  <= ipid_pkg::STEP_LIMIT_RST;
      cfg_q.drive_upper <= ipid_pkg::DRIVE_UPPER_RST;
      cfg_q.drive_lower <= ipid_pkg::DRIVE_LOWER_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/ipid_err.sv @@
module ipid_err (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ipid_pkg::in_t     in_data_i,
  output ipid_pkg::hs_t     dn_o,
  input  logic              dn_take_i,
  output ipid_pkg::diff_t   diff_o
);

  logic                              take;
  logic                              acc_beat;
  logic signed [ipid_pkg::ERR_W-1:0] err_now_q, err_prev_q;
  logic signed [ipid_pkg::ERR_W-1:0] e0;
  logic                              diff_vld_q;
  ipid_pkg::diff_t                   diff_q, diff_d;

  assign take       = !diff_vld_q || dn_take_i;
  assign in_stall_o = !take;
  assign acc_beat   = in_valid_i && take;

  // new error and the proportional and derivative differences
  always_comb begin
    e0 = {in_data_i.setpoint[ipid_pkg::IN_W-1], in_data_i.setpoint}
       - {in_data_i.measured[ipid_pkg::IN_W-1], in_data_i.measured};
    diff_d.e0 = e0;
    diff_d.dp = {e0[ipid_pkg::ERR_W-1], e0}
              - {err_now_q[ipid_pkg::ERR_W-1], err_now_q};
    diff_d.dd = {{2{e0[ipid_pkg::ERR_W-1]}}, e0}
              - {err_now_q[ipid_pkg::ERR_W-1], err_now_q, 1'b0}
              + {{2{err_prev_q[ipid_pkg::ERR_W-1]}}, err_prev_q};
  end

  // error history shifts once per accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_now_q  <= '0;
      err_prev_q <= '0;
      diff_vld_q <= 1'b0;
    end else begin
      if (acc_beat) begin
        err_now_q  <= e0;
        err_prev_q <= err_now_q;
      end
      if (take) begin
        diff_vld_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_beat) begin
      diff_q <= diff_d;
    end
  end

  assign dn_o.vld  = diff_vld_q;
  assign dn_o.take = take;
  assign diff_o    = diff_q;

endmodule

@@ rtl/ipid_mac.sv @@
module ipid_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ipid_pkg::cfg_t                      cfg_i,
  input  logic                                up_vld_i,
  output logic                                up_take_o,
  input  ipid_pkg::diff_t                     diff_i,
  output ipid_pkg::hs_t                       dn_o,
  input  logic                                dn_take_i,
  output logic signed [ipid_pkg::INC_W-1:0]   inc_o
);

  localparam int unsigned PP_W  = ipid_pkg::PP_W;
  localparam int unsigned PI_W  = ipid_pkg::PI_W;
  localparam int unsigned PD_W  = ipid_pkg::PD_W;
  localparam int unsigned INC_W = ipid_pkg::INC_W;

  logic                     prod_take, inc_take;
  logic                     prod_vld_q, inc_vld_q;
  logic signed [PP_W-1:0]   pp_q, pp_d;
  logic signed [PI_W-1:0]   pi_q, pi_d;
  logic signed [PD_W-1:0]   pd_q, pd_d;
  logic signed [INC_W-1:0]  sum, lim, inc_d, inc_q;

  assign inc_take  = !inc_vld_q || dn_take_i;
  assign prod_take = !prod_vld_q || inc_take;

  // three gain products, gains taken as unsigned
  always_comb begin
    pp_d = PP_W'($signed({1'b0, cfg_i.gain_prop}))  * PP_W'(diff_i.dp);
    pi_d = PI_W'($signed({1'b0, cfg_i.gain_integ})) * PI_W'(diff_i.e0);
    pd_d = PD_W'($signed({1'b0, cfg_i.gain_deriv})) * PD_W'(diff_i.dd);
  end

  // sum of products and slew clamp, zero limit means no clamp
  always_comb begin
    sum = {{(INC_W-PP_W){pp_q[PP_W-1]}}, pp_q}
        + {{(INC_W-PI_W){pi_q[PI_W-1]}}, pi_q}
        + {{(INC_W-PD_W){pd_q[PD_W-1]}}, pd_q};
    lim   = $signed({{(INC_W-16){1'b0}}, cfg_i.step_limit});
    inc_d = sum;
    if (cfg_i.step_limit != '0) begin
      if (sum > lim) begin
        inc_d = lim;
      end else if (sum < -lim) begin
        inc_d = -lim;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      inc_vld_q  <= 1'b0;
    end else begin
      if (prod_take) begin
        prod_vld_q <= up_vld_i;
      end
      if (inc_take) begin
        inc_vld_q <= prod_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_take && up_vld_i) begin
      pp_q <= pp_d;
      pi_q <= pi_d;
      pd_q <= pd_d;
    end
    if (inc_take && prod_vld_q) begin
      inc_q <= inc_d;
    end
  end

  assign up_take_o = prod_take;
  assign dn_o.vld  = inc_vld_q;
  assign dn_o.take = inc_take;
  assign inc_o     = inc_q;

endmodule

@@ rtl/ipid_drive.sv @@
module ipid_drive #(
  parameter int unsigned FRAC_BITS = ipid_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ipid_pkg::cfg_t                     cfg_i,
  input  logic                               up_vld_i,
  output logic                               up_take_o,
  input  logic signed [ipid_pkg::INC_W-1:0]  inc_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output ipid_pkg::out_t                     out_data_o
);

  localparam int unsigned INC_W   = ipid_pkg::INC_W;
  localparam int unsigned ACC_W   = ipid_pkg::ACC_W;
  localparam int unsigned DRIVE_W = ipid_pkg::DRIVE_W;
  localparam int unsigned DUTY_W  = ipid_pkg::DUTY_W;
  localparam logic signed [ACC_W-1:0] DRIVE_MAX = ACC_W'((64'sd1 <<< (DRIVE_W-1)) - 1);
  localparam logic signed [ACC_W-1:0] DRIVE_MIN = ACC_W'(-(64'sd1 <<< (DRIVE_W-1)));
  localparam logic signed [DRIVE_W-1:0] DUTY_MAX = DRIVE_W'((64'sd1 <<< (DUTY_W-1)) - 1);
  localparam logic signed [DRIVE_W-1:0] DUTY_MIN = DRIVE_W'(-(64'sd1 <<< (DUTY_W-1)));
  localparam logic [DRIVE_W-1:0] FRAC_MASK = DRIVE_W'((64'd1 << FRAC_BITS) - 1);

  logic                        take, beat;
  logic                        out_vld_q;
  logic signed [DRIVE_W-1:0]   drive_acc_q;
  logic signed [ACC_W-1:0]     acc, hi, lo;
  logic signed [DRIVE_W-1:0]   drive_d, quot, duty_w;
  ipid_pkg::out_t              out_q, out_d;

  assign take = !out_vld_q || !out_stall_i;
  assign beat = up_vld_i && take;

  // accumulate, clamp to bounds (upper first) and to the accumulator range
  always_comb begin
    hi  = $signed({{(ACC_W-16){cfg_i.drive_upper[15]}}, cfg_i.drive_upper}) <<< FRAC_BITS;
    lo  = $signed({{(ACC_W-16){cfg_i.drive_lower[15]}}, cfg_i.drive_lower}) <<< FRAC_BITS;
    acc = {{(ACC_W-DRIVE_W){drive_acc_q[DRIVE_W-1]}}, drive_acc_q}
        + {{(ACC_W-INC_W){inc_i[INC_W-1]}}, inc_i};
    if (acc > hi) begin
      acc = hi;
    end
    if (acc < lo) begin
      acc = lo;
    end
    if (acc > DRIVE_MAX) begin
      acc = DRIVE_MAX;
    end
    if (acc < DRIVE_MIN) begin
      acc = DRIVE_MIN;
    end
    drive_d = acc[DRIVE_W-1:0];
  end

  // whole duty, truncated toward zero and saturated
  always_comb begin
    quot = drive_d >>> FRAC_BITS;
    if (drive_d[DRIVE_W-1] && ((drive_d & FRAC_MASK) != '0)) begin
      quot = quot + DRIVE_W'(1);
    end
    duty_w = quot;
    if (quot > DUTY_MAX) begin
      duty_w = DUTY_MAX;
    end else if (quot < DUTY_MIN) begin
      duty_w = DUTY_MIN;
    end
    out_d.duty        = duty_w[DUTY_W-1:0];
    out_d.drive_fixed = drive_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_acc_q <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      if (beat) begin
        drive_acc_q <= drive_d;
      end
      if (take) begin
        out_vld_q <= up_vld_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat) begin
      out_q <= out_d;
    end
  end

  assign up_take_o   = take;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
